// ===== sv/avw_pkg.sv =====
// Shared types, widths and codes for the ADSR wavetable voice.
// No dependencies; compiled first.
package avw_pkg;

    localparam int PHASE_SHIFT_DEF = 24;

    localparam int ACTION_W   = 2;
    localparam int LEVEL_W    = 8;
    localparam int FRAMES_W   = 24;
    localparam int LEFT_W     = 26;
    localparam int PHASE_W    = 32;
    localparam int MIX_W      = 16;
    localparam int WAVE_W     = 16;
    localparam int ADDR_W     = 8;
    localparam int WAVE_DEPTH = 256;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Divider: quotient is the 8-bit level, one bit per step
    localparam int DIV_STEPS  = LEVEL_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int NUM_W      = LEVEL_W + FRAMES_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RENDER = 2'd0,
        ACT_START  = 2'd1,
        ACT_LOAD   = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACK_LEVEL   = 3'd0,
        REG_SUSTAIN_LEVEL  = 3'd1,
        REG_ATTACK_FRAMES  = 3'd2,
        REG_DECAY_FRAMES   = 3'd3,
        REG_SUSTAIN_FRAMES = 3'd4,
        REG_RELEASE_FRAMES = 3'd5,
        REG_START_STEP     = 3'd6,
        REG_STEP_GLIDE     = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        STG_IDLE    = 3'd0,
        STG_ATTACK  = 3'd1,
        STG_DECAY   = 3'd2,
        STG_SUSTAIN = 3'd3,
        STG_RELEASE = 3'd4
    } env_stage_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NUM_A,
        ST_NUM_B,
        ST_DIV,
        ST_SCALE,
        ST_DONE
    } fsm_state_t;

    // A zero length counts as one frame
    function automatic logic [FRAMES_W-1:0] len_or_one(input logic [FRAMES_W-1:0] v);
        logic [FRAMES_W-1:0] r;
        r = (v == '0) ? FRAMES_W'(1) : v;
        return r;
    endfunction

endpackage

// ===== sv/avw_if.sv =====
// Channel interfaces of the ADSR wavetable voice: request, result, register write.
// Depends on avw_pkg for field widths.
interface avw_req_if;
    logic                               valid;
    logic                               ready;
    logic [avw_pkg::ACTION_W-1:0]       action;
    logic signed [avw_pkg::MIX_W-1:0]   mix_in;
    logic [avw_pkg::ADDR_W-1:0]         wave_addr;
    logic signed [avw_pkg::WAVE_W-1:0]  wave_value;

    modport source (output valid, output action, output mix_in, output wave_addr,
                    output wave_value, input ready);
    modport sink   (input valid, input action, input mix_in, input wave_addr,
                    input wave_value, output ready);
endinterface

interface avw_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [avw_pkg::MIX_W-1:0]   mix_out;
    logic                               voice_active;

    modport source (output valid, output mix_out, output voice_active, input ready);
    modport sink   (input valid, input mix_out, input voice_active, output ready);
endinterface

interface avw_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [avw_pkg::CFG_IDX_W-1:0]      index;
    logic [avw_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/adsr_wavetable_voice.sv =====
// ADSR wavetable voice top level: sequencer, shared divider, wave memory.
// Depends on avw_pkg and the channel interfaces in avw_if.sv.
//
// One synthesizer voice. A load request writes one word of the 256-entry wave
// memory; a start request latches the envelope registers and restarts the note;
// a render request adds one voice frame into mix_in and returns one result.
// Load and start return nothing. A render of a sounding voice runs from
// acceptance through these steps: the NUM_A and NUM_B multiply steps form the
// interpolation numerator, the shared compare/subtract unit then produces the
// 8-bit level one bit per cycle, the scale step scales the wave sample,
// and the done step loads the output register. A silent voice's render skips
// to the done step. The block takes no request while a render is in progress;
// a result waiting in the output register does not stall the next request
// until a new result is ready to replace it. Register writes are always taken.
module adsr_wavetable_voice #(
    parameter int PHASE_SHIFT = avw_pkg::PHASE_SHIFT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    avw_cfg_if.sink   cfg,
    avw_req_if.sink   req,
    avw_rsp_if.source rsp
);
    import avw_pkg::*;

    // Configuration registers
    logic [LEVEL_W-1:0]    attack_level_reg, sustain_level_reg;
    logic [FRAMES_W-1:0]   attack_frames_reg, decay_frames_reg;
    logic [FRAMES_W-1:0]   sustain_frames_reg, release_frames_reg;
    logic [PHASE_W-1:0]    start_step_reg, step_glide_reg;

    // Values latched at note start
    logic [LEVEL_W-1:0]    lat_atk_lvl_reg, lat_sus_lvl_reg;
    logic [FRAMES_W-1:0]   lat_dec_len_reg, lat_sus_len_reg, lat_rel_len_reg;
    logic [PHASE_W-1:0]    lat_glide_reg;

    // Voice state
    env_stage_t            stage_reg;
    logic [LEVEL_W-1:0]    seg_start_level_reg, seg_end_level_reg;
    logic [FRAMES_W-1:0]   seg_length_reg, seg_pos_reg;
    logic [LEFT_W-1:0]     frames_left_reg;
    logic [PHASE_W-1:0]    phase_reg, phase_step_reg;

    // Sequencer and datapath
    fsm_state_t            state_reg, state_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [NUM_W-1:0]      rem_reg, dsh_reg;
    logic [LEVEL_W-1:0]    quot_reg;
    logic signed [WAVE_W+LEVEL_W:0] prod_reg;
    logic signed [MIX_W-1:0] mix_reg;
    logic                  active_reg;
    logic signed [WAVE_W-1:0] wave_q_reg;

    // Output register
    logic                  rsp_valid_reg;
    logic signed [MIX_W-1:0] mix_out_reg;
    logic                  voice_active_reg;

    // Wave memory, contents undefined until written
    logic [WAVE_W-1:0]     wave_mem [WAVE_DEPTH];

    logic                  req_fire, out_load, div_ge;
    logic                  is_render, is_start, is_load;
    logic [PHASE_W-1:0]    phase_sh;
    logic [ADDR_W-1:0]     rd_addr;
    logic [FRAMES_W:0]     pos_inc;
    logic                  seg_over;
    logic [FRAMES_W-1:0]   atk_len;
    logic [LEFT_W-1:0]     total_len;

    assign is_render = (req.action == ACT_RENDER);
    assign is_start  = (req.action == ACT_START);
    assign is_load   = (req.action == ACT_LOAD);
    assign req_fire  = req.valid && req.ready;

    assign phase_sh  = phase_reg >> PHASE_SHIFT;
    assign rd_addr   = phase_sh[ADDR_W-1:0];
    assign div_ge    = (rem_reg >= dsh_reg);
    assign pos_inc   = {1'b0, seg_pos_reg} + (FRAMES_W+1)'(1);
    assign seg_over  = (pos_inc >= {1'b0, seg_length_reg});
    assign atk_len   = len_or_one(attack_frames_reg);
    assign total_len = LEFT_W'(atk_len) + LEFT_W'(len_or_one(decay_frames_reg))
                     + LEFT_W'(len_or_one(sustain_frames_reg))
                     + LEFT_W'(len_or_one(release_frames_reg));

    assign cfg.ready       = 1'b1;
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.mix_out     = mix_out_reg;
    assign rsp.voice_active = voice_active_reg;

    // Sequencer: next state and handshake
    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid && is_render)
                begin
                    state_next = (frames_left_reg == '0) ? ST_DONE : ST_NUM_A;
                end
            end
            ST_NUM_A:
            begin
                state_next = ST_NUM_B;
            end
            ST_NUM_B:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_level_reg   <= '0;
            sustain_level_reg  <= '0;
            attack_frames_reg  <= FRAMES_W'(1);
            decay_frames_reg   <= FRAMES_W'(1);
            sustain_frames_reg <= FRAMES_W'(1);
            release_frames_reg <= FRAMES_W'(1);
            start_step_reg     <= '0;
            step_glide_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_ATTACK_LEVEL:   attack_level_reg   <= cfg.data[LEVEL_W-1:0];
                REG_SUSTAIN_LEVEL:  sustain_level_reg  <= cfg.data[LEVEL_W-1:0];
                REG_ATTACK_FRAMES:  attack_frames_reg  <= cfg.data[FRAMES_W-1:0];
                REG_DECAY_FRAMES:   decay_frames_reg   <= cfg.data[FRAMES_W-1:0];
                REG_SUSTAIN_FRAMES: sustain_frames_reg <= cfg.data[FRAMES_W-1:0];
                REG_RELEASE_FRAMES: release_frames_reg <= cfg.data[FRAMES_W-1:0];
                REG_START_STEP:     start_step_reg     <= cfg.data[PHASE_W-1:0];
                REG_STEP_GLIDE:     step_glide_reg     <= cfg.data[PHASE_W-1:0];
                default:            ;
            endcase
        end
    end

    // Voice state: note start, and end-of-frame envelope/phase update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_atk_lvl_reg     <= '0;
            lat_sus_lvl_reg     <= '0;
            lat_dec_len_reg     <= FRAMES_W'(1);
            lat_sus_len_reg     <= FRAMES_W'(1);
            lat_rel_len_reg     <= FRAMES_W'(1);
            lat_glide_reg       <= '0;
            stage_reg           <= STG_IDLE;
            seg_start_level_reg <= '0;
            seg_end_level_reg   <= '0;
            seg_length_reg      <= '1;
            seg_pos_reg         <= '0;
            frames_left_reg     <= '0;
            phase_reg           <= '0;
            phase_step_reg      <= '0;
        end
        else if (req_fire && is_start)
        begin
            lat_atk_lvl_reg     <= attack_level_reg;
            lat_sus_lvl_reg     <= sustain_level_reg;
            lat_dec_len_reg     <= len_or_one(decay_frames_reg);
            lat_sus_len_reg     <= len_or_one(sustain_frames_reg);
            lat_rel_len_reg     <= len_or_one(release_frames_reg);
            lat_glide_reg       <= step_glide_reg;
            stage_reg           <= STG_ATTACK;
            seg_start_level_reg <= '0;
            seg_end_level_reg   <= attack_level_reg;
            seg_length_reg      <= atk_len;
            seg_pos_reg         <= '0;
            frames_left_reg     <= total_len;
            phase_reg           <= '0;
            phase_step_reg      <= start_step_reg;
        end
        else if (state_reg == ST_SCALE)
        begin
            frames_left_reg <= frames_left_reg - LEFT_W'(1);
            phase_reg       <= phase_reg + phase_step_reg;
            phase_step_reg  <= phase_step_reg + lat_glide_reg;
            if (seg_over)
            begin
                seg_pos_reg <= '0;
                unique case (stage_reg)
                    STG_ATTACK:
                    begin
                        stage_reg           <= STG_DECAY;
                        seg_start_level_reg <= lat_atk_lvl_reg;
                        seg_end_level_reg   <= lat_sus_lvl_reg;
                        seg_length_reg      <= lat_dec_len_reg;
                    end
                    STG_DECAY:
                    begin
                        stage_reg           <= STG_SUSTAIN;
                        seg_start_level_reg <= lat_sus_lvl_reg;
                        seg_end_level_reg   <= lat_sus_lvl_reg;
                        seg_length_reg      <= lat_sus_len_reg;
                    end
                    STG_SUSTAIN:
                    begin
                        stage_reg           <= STG_RELEASE;
                        seg_start_level_reg <= lat_sus_lvl_reg;
                        seg_end_level_reg   <= '0;
                        seg_length_reg      <= lat_rel_len_reg;
                    end
                    default:
                    begin
                        stage_reg           <= STG_IDLE;
                        seg_start_level_reg <= '0;
                        seg_end_level_reg   <= '0;
                        seg_length_reg      <= '1;
                    end
                endcase
            end
            else
            begin
                seg_pos_reg <= pos_inc[FRAMES_W-1:0];
            end
        end
    end

    // Wave memory: write on load, registered read at the phase index
    always_ff @(posedge clk)
    begin
        if (req_fire && is_load)
        begin
            wave_mem[req.wave_addr] <= req.wave_value;
        end
        wave_q_reg <= wave_mem[rd_addr];
    end

    // Level datapath: numerator, shared compare/subtract divider, scaling
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                mix_reg    <= req.mix_in;
                prod_reg   <= '0;
                active_reg <= (frames_left_reg != '0);
            end
            ST_NUM_A:
            begin
                // start level times remaining frames of the segment
                rem_reg <= NUM_W'(seg_start_level_reg)
                         * NUM_W'(seg_length_reg - seg_pos_reg);
                dsh_reg <= {1'b0, seg_length_reg, (LEVEL_W-1)'(0)};
            end
            ST_NUM_B:
            begin
                // plus end level times elapsed frames
                rem_reg     <= rem_reg + NUM_W'(seg_end_level_reg) * NUM_W'(seg_pos_reg);
                div_cnt_reg <= '0;
                quot_reg    <= '0;
            end
            ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                quot_reg    <= {quot_reg[LEVEL_W-2:0], div_ge};
                dsh_reg     <= dsh_reg >> 1;
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            ST_SCALE:
            begin
                prod_reg <= wave_q_reg * $signed({1'b0, quot_reg});
            end
            default:
            begin
            end
        endcase
    end

    // Output register; level/256 rounds toward minus infinity by the shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            mix_out_reg      <= mix_reg + prod_reg[MIX_W+LEVEL_W-1:LEVEL_W];
            voice_active_reg <= active_reg;
        end
    end

    // A silent voice sits in the idle segment
    a_silent_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (frames_left_reg == '0) |-> (stage_reg == STG_IDLE))
        else $error("frames exhausted outside idle segment");

    // While sounding, position stays inside the segment
    a_pos_in_seg: assert property (@(posedge clk) disable iff (!rst_n)
        (frames_left_reg != '0) |-> (seg_pos_reg < seg_length_reg))
        else $error("segment position beyond segment length");

    // Interpolated level is not above both segment endpoints
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE) |->
        (quot_reg <= seg_start_level_reg || quot_reg <= seg_end_level_reg))
        else $error("level above both segment endpoints");

    // A render of a sounding voice enters the numerator step
    a_render_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && is_render && frames_left_reg != '0) |=> (state_reg == ST_NUM_A))
        else $error("render did not start the level computation");

endmodule
